[design/fwbc_pkg.sv]
// ----------------------------------------------------------------------------
// fwbc_pkg: shared types and constants of the flash write block coalescer
// Field widths, operation and register codes, the result record and the
// byte mask helper used by the packer.
// ----------------------------------------------------------------------------
`default_nettype none

package fwbc_pkg;

   localparam int ADDR_W          = 32;
   localparam int SLOT_W          = 25;
   localparam int FILL_W          = 4;
   localparam int BYTE_W          = 8;
   localparam int DATA_W          = 64;
   localparam int OP_W            = 2;
   localparam int CSR_IDX_W       = 1;
   localparam int MAX_BLOCK_BYTES = DATA_W / BYTE_W;
   localparam int DEF_BLOCK_BYTES = 8;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_DATA  = 2'd0,
      OP_FLUSH = 2'd1,
      OP_START = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_BASE = 1'b0,
      CSR_SLOT_BYTES  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] target_base;
      logic [SLOT_W-1:0] slot_bytes;
   } cfg_type;

   typedef struct packed {
      logic              status;
      logic              block_valid;
      logic [ADDR_W-1:0] block_address;
      logic [DATA_W-1:0] block_data;
   } rsp_type;

   // Ones in every byte lane below n
   function automatic logic [DATA_W-1:0] low_bytes_mask(input logic [FILL_W-1:0] n);
      logic [DATA_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
         if (FILL_W'(i) < n) begin
            mask[i*BYTE_W +: BYTE_W] = '1;
         end
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

[design/fwbc_channels.sv]
// ----------------------------------------------------------------------------
// fwbc channels: request and response handshake interfaces
// Valid/ready channels carrying the operation stream and the block results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwbc_req_if;
   import fwbc_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface fwbc_rsp_if;
   import fwbc_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic              block_valid;
   logic [ADDR_W-1:0] block_address;
   logic [DATA_W-1:0] block_data;

   modport source (output valid, output status, output block_valid,
                   output block_address, output block_data, input ready);
   modport sink   (input valid, input status, input block_valid,
                   input block_address, input block_data, output ready);
endinterface

`default_nettype wire

[design/fwbc_packer.sv]
// ----------------------------------------------------------------------------
// fwbc_packer: slot offset, fill count and partial block state
// Places bytes into the partial block, checks slot bounds, pads on flush and
// forms the result for each transfer in the cycle it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fwbc_packer
   import fwbc_pkg::*;
#(
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              accept,
   input  wire logic [OP_W-1:0]   operation,
   input  wire logic [BYTE_W-1:0] data_byte,
   output rsp_type                result
);

   localparam logic [FILL_W-1:0] BLK_FILL = FILL_W'(BLOCK_BYTES);
   localparam logic [SLOT_W+1:0] BLK_ADV  = (SLOT_W+2)'(BLOCK_BYTES);
   localparam logic [DATA_W-1:0] BLK_MASK = low_bytes_mask(BLK_FILL);

   logic [SLOT_W-1:0] offset_ff, offset_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [DATA_W-1:0] partial_ff, partial_in;

   logic [SLOT_W+1:0] byte_end;
   logic [SLOT_W+1:0] block_end;
   logic              byte_fits;
   logic              block_fits;
   logic [FILL_W-1:0] fill_next;
   logic [DATA_W-1:0] merged;
   logic [DATA_W-1:0] pad;

   assign byte_end   = {2'b00, offset_ff} + {{(SLOT_W+2-FILL_W){1'b0}}, fill_ff}
                       + (SLOT_W+2)'(1);
   assign block_end  = {2'b00, offset_ff} + BLK_ADV;
   assign byte_fits  = byte_end  <= {2'b00, cfg.slot_bytes};
   assign block_fits = block_end <= {2'b00, cfg.slot_bytes};
   assign fill_next  = fill_ff + FILL_W'(1);
   assign merged     = partial_ff
                       | ({{(DATA_W-BYTE_W){1'b0}}, data_byte} << {fill_ff[2:0], 3'b000});
   assign pad        = {MAX_BLOCK_BYTES{PAD_BYTE}} & BLK_MASK & ~low_bytes_mask(fill_ff);

   always_comb begin
      offset_in            = offset_ff;
      fill_in              = fill_ff;
      partial_in           = partial_ff;
      result.status        = 1'b0;
      result.block_valid   = 1'b0;
      result.block_address = '0;
      result.block_data    = '0;
      unique case (operation)
         OP_DATA: begin
            if (!byte_fits) begin
               result.status = 1'b1;
            end else if (fill_next == BLK_FILL) begin
               result.block_valid   = 1'b1;
               result.block_address = cfg.target_base + ADDR_W'(offset_ff);
               result.block_data    = merged & BLK_MASK;
               offset_in            = block_end[SLOT_W-1:0];
               fill_in              = '0;
               partial_in           = '0;
            end else begin
               fill_in    = fill_next;
               partial_in = merged;
            end
         end
         OP_FLUSH: begin
            if (fill_ff != '0) begin
               if (!block_fits) begin
                  result.status = 1'b1;
               end else begin
                  result.block_valid   = 1'b1;
                  result.block_address = cfg.target_base + ADDR_W'(offset_ff);
                  result.block_data    = (partial_ff | pad) & BLK_MASK;
                  offset_in            = block_end[SLOT_W-1:0];
                  fill_in              = '0;
                  partial_in           = '0;
               end
            end
         end
         OP_START: begin
            offset_in  = '0;
            fill_in    = '0;
            partial_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         fill_ff    <= '0;
         partial_ff <= '0;
      end else if (accept) begin
         offset_ff  <= offset_in;
         fill_ff    <= fill_in;
         partial_ff <= partial_in;
      end
   end

   a_fill_below_block: assert property (@(posedge clock) disable iff (reset)
      fill_ff < BLK_FILL)
      else $error("fill count reached block size");

   a_unfilled_zero: assert property (@(posedge clock) disable iff (reset)
      (partial_ff & ~low_bytes_mask(fill_ff)) == '0)
      else $error("partial block holds bytes past the fill");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && operation == OP_START |=> offset_ff == '0 && fill_ff == '0)
      else $error("start did not clear offset and fill");

   a_emit_ok: assert property (@(posedge clock) disable iff (reset)
      result.block_valid |-> !result.status)
      else $error("block emitted with rejected status");

   a_emit_advance: assert property (@(posedge clock) disable iff (reset)
      accept && result.block_valid |=>
         fill_ff == '0 && offset_ff == $past(offset_ff) + SLOT_W'(BLOCK_BYTES))
      else $error("offset did not advance after emitted block");

endmodule

`default_nettype wire

[design/flash_write_block_coalescer.sv]
// ----------------------------------------------------------------------------
// flash_write_block_coalescer: packs a byte stream into aligned flash blocks
//
// req_ch carries one operation per transfer: a data byte, a flush of the
// partial block (padded with 0xFF) or a start of a new slot. Every request
// gives exactly one response on rsp_ch with status (1 = slot bound would be
// exceeded, nothing changed), and when a block completes, block_valid with
// its flash address (target base plus slot offset) and data, byte 0 lowest.
// The response is registered at the edge that takes the request. Throughput
// is one request per cycle unless rsp_ch stalls; the offset/fill update and
// the bound compare are combinational, ahead of the response register. A
// stalled response holds in its register; req_ch.ready stays high while that
// register is empty or being drained in the same cycle. The user writes csr_
// registers (target base, slot size) only while idle, unchecked by the block.
// Reset clears offset, fill, partial block, both registers and rsp valid.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_write_block_coalescer
   import fwbc_pkg::*;
#(
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   fwbc_req_if.sink                  req_ch,
   fwbc_rsp_if.source                rsp_ch,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_write_data
);

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   rsp_type result;
   logic    rsp_valid_ff;
   logic    accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_BASE: cfg_ff.target_base <= csr_write_data;
            CSR_SLOT_BYTES:  cfg_ff.slot_bytes  <= csr_write_data[SLOT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   fwbc_packer #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .operation (req_ch.operation),
      .data_byte (req_ch.data_byte),
      .result    (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.block_valid   = rsp_ff.block_valid;
   assign rsp_ch.block_address = rsp_ff.block_address;
   assign rsp_ch.block_data    = rsp_ff.block_data;

endmodule

`default_nettype wire
